// ===== hw/rtl/mhpq_pkg.sv =====
// Shared types and constants of the max-heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mhpq_pkg;

    localparam int DATA_W       = 32;
    localparam int CNT_OUT_W    = 7;
    localparam int OUT_DATA_W   = 2 * DATA_W + CNT_OUT_W + 1;
    localparam int CAPACITY_DEF = 64;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic up_chk;
        logic up_cmp;
        logic last_load;
        logic dn_chk;
        logic dn_cmp;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_pop;
        logic full;
        logic empty;
        logic count_one;
        logic up_root;
        logic up_more;
        logic dn_leaf;
        logic dn_more;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Max-heap priority queue of signed 32-bit values: top level.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp (which holds the mhpq_ram store).
//
// Usage:
// Each request on the slave stream is one operation: tuser selects push (0)
// or pop (1), tdata carries the value to push. Every request yields exactly
// one result on the master stream: the popped value (0 for a push or an
// empty pop), the maximum left in the heap (0 when empty), the entry count
// modulo 128, an empty flag and a status in tuser (0 ok, 1 push dropped
// because full, 2 pop on an empty heap).
// One request at a time: a new request is taken only once the last one has
// finished and its result has been loaded into the result register. A push
// rises one level per check and compare step until it stops or reaches the
// root; a pop moves the last entry to the root and sinks it likewise; a
// dropped push, an empty pop or a pop of the only entry goes straight to the
// result. The sift loop needs one registered store read and one compare per
// level through the single heap store.
// Reset empties the heap at once; the store itself is not cleared.
// If the receiver stalls, the finished result waits in the output register;
// the next request is still taken and worked on, and its result waits until
// the previous one has been taken.
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: value[31:0]
    input  wire logic [mhpq_pkg::DATA_W-1:0]     i_s_axis_tdata,
    // tuser: operation[0]
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: popped_value[31:0], top_value[63:32], entry_count[70:64], is_empty[71]
    output logic      [mhpq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[1:0]
    output logic      [1:0]                      o_m_axis_tuser
);

    import mhpq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (i_s_axis_tuser),
        .i_value (i_s_axis_tdata),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mhpq_ram.sv =====
// Generic simple RAM: one write port, two read ports with registered read data.
// Stands alone; used for the heap store.
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== hw/rtl/mhpq_ctrl.sv =====
// Controller state machine of the max-heap priority queue: sequences the sifts.
// Depends on mhpq_pkg for the command and status structs.
`default_nettype none

module mhpq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    input  wire mhpq_pkg::t_stat i_stat,
    output mhpq_pkg::t_cmd       o_cmd
);

    import mhpq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_CHK = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_LAST   = 7'b0001000,
        S_DN_CHK = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    cmd.start = 1'b1;
                    if (i_stat.op_pop) begin
                        if (i_stat.empty || i_stat.count_one) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_LAST;
                        end
                    end else if (i_stat.full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_UP_CHK;
                    end
                end
            end
            S_UP_CHK: begin
                cmd.up_chk = 1'b1;
                n_state    = i_stat.up_root ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                cmd.up_cmp = 1'b1;
                n_state    = i_stat.up_more ? S_UP_CHK : S_DONE;
            end
            S_LAST: begin
                cmd.last_load = 1'b1;
                n_state       = S_DN_CHK;
            end
            S_DN_CHK: begin
                cmd.dn_chk = 1'b1;
                n_state    = i_stat.dn_leaf ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP: begin
                cmd.dn_cmp = 1'b1;
                n_state    = i_stat.dn_more ? S_DN_CHK : S_DONE;
            end
            S_DONE: begin
                // The result register is refilled only once the last result has gone.
                if (!r_ovalid || i_m_axis_tready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_cmd           = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/mhpq_dp.sv =====
// Datapath of the max-heap priority queue: fill count, root copy, moving entry,
// sift position, heap store and result register. Depends on mhpq_pkg and mhpq_ram.
`default_nettype none

module mhpq_dp #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_op,
    input  wire logic [mhpq_pkg::DATA_W-1:0]     i_value,
    input  wire mhpq_pkg::t_cmd                  i_cmd,
    output mhpq_pkg::t_stat                      o_stat,
    output logic      [mhpq_pkg::OUT_DATA_W-1:0] o_data,
    output logic      [1:0]                      o_user
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int EW = CW + CNT_OUT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]         r_count, n_count;
    logic [DATA_W-1:0]     r_top, n_top;
    logic [DATA_W-1:0]     r_val, n_val;
    logic [AW-1:0]         r_pos, n_pos;
    t_status               r_status, n_status;
    logic [DATA_W-1:0]     r_popped, n_popped;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [1:0]            r_ouser;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;

    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     pos_m1;
    logic [AW-1:0]     parent;
    logic [XW-1:0]     left_w;
    logic [XW-1:0]     right_w;
    logic [XW-1:0]     count_x;
    logic              left_ok;
    logic              right_ok;
    logic              pick_right;
    logic [DATA_W-1:0] pick_val;
    logic [AW-1:0]     pick_addr;
    logic              up_more;
    logic              dn_more;
    logic [EW-1:0]     count_ext;

    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign cnt_m1   = r_count - CW'(1);
    assign pos_m1   = r_pos - AW'(1);
    assign parent   = pos_m1 >> 1;
    assign left_w   = {1'b0, r_pos, 1'b1};
    assign right_w  = left_w + XW'(1);
    assign count_x  = {{(XW - CW){1'b0}}, r_count};
    assign left_ok  = (left_w < count_x);
    assign right_ok = (right_w < count_x);

    // Ties go to the left child: the right one wins only when strictly greater.
    assign pick_right = right_ok && ($signed(rdata_b) > $signed(rdata_a));
    assign pick_val   = pick_right ? rdata_b : rdata_a;
    assign pick_addr  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
    assign up_more    = ($signed(r_val) > $signed(rdata_a));
    assign dn_more    = ($signed(pick_val) > $signed(r_val));

    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_val    = r_val;
        n_pos    = r_pos;
        n_status = r_status;
        n_popped = r_popped;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_val;
        raddr_a  = parent;
        raddr_b  = left_w[AW-1:0];

        if (i_cmd.start) begin
            n_status = ST_OK;
            n_popped = '0;
            if (i_op == OP_POP) begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    // The root leaves; the last entry is fetched to refill it.
                    n_popped = r_top;
                    n_count  = cnt_m1;
                    n_pos    = '0;
                    raddr_a  = cnt_m1[AW-1:0];
                end
            end else if (r_count == CAP_C) begin
                n_status = ST_FULL;
            end else begin
                n_val   = i_value;
                n_pos   = r_count[AW-1:0];
                n_count = r_count + CW'(1);
            end
        end

        // Sifts move a hole rather than swapping, so each level costs one write.
        if (i_cmd.up_chk && (r_pos == '0)) begin
            we    = 1'b1;
            n_top = r_val;
        end

        if (i_cmd.up_cmp) begin
            we = 1'b1;
            if (up_more) begin
                wdata = rdata_a;
                n_pos = parent;
            end
        end

        if (i_cmd.last_load) begin
            n_val = rdata_a;
        end

        if (i_cmd.dn_chk) begin
            raddr_a = left_w[AW-1:0];
            raddr_b = right_ok ? right_w[AW-1:0] : left_w[AW-1:0];
            if (!left_ok) begin
                we = 1'b1;
                if (r_pos == '0) begin
                    n_top = r_val;
                end
            end
        end

        if (i_cmd.dn_cmp) begin
            we = 1'b1;
            if (dn_more) begin
                wdata = pick_val;
                n_pos = pick_addr;
            end
            if (r_pos == '0) begin
                n_top = wdata;
            end
        end
    end

    assign count_ext = {{CNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_popped <= n_popped;
        if (i_cmd.load_out) begin
            r_odata <= {(r_count == '0), count_ext[CNT_OUT_W-1:0],
                        ((r_count == '0) ? {DATA_W{1'b0}} : r_top), r_popped};
            r_ouser <= r_status;
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.op_pop    = (i_op == OP_POP);
        o_stat.full      = (r_count == CAP_C);
        o_stat.empty     = (r_count == '0);
        o_stat.count_one = (r_count == CW'(1));
        o_stat.up_root   = (r_pos == '0);
        o_stat.up_more   = up_more;
        o_stat.dn_leaf   = !left_ok;
        o_stat.dn_more   = dn_more;
    end

    assign o_data = r_odata;
    assign o_user = r_ouser;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the max-heap priority queue.
// Depends on mhpq_pkg and max_heap_priority_queue. A shadow heap in the bench
// predicts each result, and a checker compares every result field by field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    localparam int HEAP_DEPTH     = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] top;
        logic [CNT_OUT_W-1:0]     count;
        logic                     empty;
        t_status                  status;
    } heap_outcome_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_tdata  = '0;
    logic                  s_tuser  = OP_PUSH;
    logic                  m_tready = 1'b0;
    logic                  dut_s_tready;
    logic                  dut_m_tvalid;
    logic [OUT_DATA_W-1:0] dut_m_tdata;
    logic [1:0]            dut_m_tuser;

    // Shadow copy of the heap that the predictor keeps in step with the block.
    logic signed [DATA_W-1:0] shadow_heap [HEAP_DEPTH];
    int                       shadow_fill = 0;
    heap_outcome_t            awaited_outcomes [$];

    bit quiet_mode  = 1'b0;
    int hold_req    = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int mismatches  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int full_drops  = 0;
    int empty_pops  = 0;

    max_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(dut_s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(dut_m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (dut_m_tdata),
        .o_m_axis_tuser (dut_m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic heap_outcome_t apply_to_shadow_heap(input logic op,
                                                           input logic [DATA_W-1:0] val);
        heap_outcome_t            res;
        int                       pos;
        int                       parent;
        int                       left;
        int                       pick;
        bit                       done;
        logic signed [DATA_W-1:0] tmp;
        res        = '0;
        res.status = ST_OK;
        if (op == OP_PUSH) begin
            if (shadow_fill >= HEAP_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_heap[shadow_fill] = val;
                pos = shadow_fill;
                shadow_fill++;
                done = 1'b0;
                while (pos > 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[pos] > shadow_heap[parent]) begin
                        tmp                 = shadow_heap[pos];
                        shadow_heap[pos]    = shadow_heap[parent];
                        shadow_heap[parent] = tmp;
                        pos = parent;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else begin
            if (shadow_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.popped = shadow_heap[0];
                shadow_fill--;
                shadow_heap[0] = shadow_heap[shadow_fill];
                pos  = 0;
                done = 1'b0;
                while (!done) begin
                    left = 2 * pos + 1;
                    if (left >= shadow_fill) begin
                        done = 1'b1;
                    end else begin
                        // The right child wins only when strictly greater, so ties go left.
                        pick = left;
                        if (left + 1 < shadow_fill && shadow_heap[left + 1] > shadow_heap[left])
                            pick = left + 1;
                        if (shadow_heap[pick] > shadow_heap[pos]) begin
                            tmp               = shadow_heap[pos];
                            shadow_heap[pos]  = shadow_heap[pick];
                            shadow_heap[pick] = tmp;
                            pos = pick;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        res.top   = (shadow_fill != 0) ? shadow_heap[0] : '0;
        res.count = shadow_fill[CNT_OUT_W-1:0];
        res.empty = (shadow_fill == 0);
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_value(input int style);
        logic [DATA_W-1:0] v;
        case (style)
            0: v = $urandom;
            1: v = $urandom_range(0, 15) - 8;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offers one request, waits for it to be taken and records its outcome.
    task automatic send_request(input logic op, input logic [DATA_W-1:0] val);
        heap_outcome_t want;
        while (!quiet_mode && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        @(posedge clk);
        while (!dut_s_tready) @(posedge clk);
        want = apply_to_shadow_heap(op, val);
        awaited_outcomes.push_back(want);
        requests_sent++;
        if (want.status == ST_FULL)  full_drops++;
        if (want.status == ST_EMPTY) empty_pops++;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d: %s expected %0d, got %0d",
                         results_checked, name, want, got);
        end
    endtask

    always @(posedge clk) begin : check_results
        heap_outcome_t want;
        if (rst_n && dut_m_tvalid && m_tready) begin
            if (awaited_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result with no request outstanding");
            end else begin
                want = awaited_outcomes.pop_front();
                compare_field("popped value", want.popped, $signed(dut_m_tdata[31:0]));
                compare_field("top value", want.top, $signed(dut_m_tdata[63:32]));
                compare_field("entry count", want.count, dut_m_tdata[70:64]);
                compare_field("empty flag", want.empty, dut_m_tdata[71]);
                compare_field("status", want.status, dut_m_tuser);
            end
            results_checked++;
        end
    end

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!quiet_mode && $urandom_range(0, 99) < 33) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && dut_s_tready) || (dut_m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_request(OP_POP, 32'h1234_5678);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        // Equal values exercise the tie rules in both sift directions.
        repeat (3) send_request(OP_PUSH, 32'd5);
        send_request(OP_PUSH, 32'hAAAA_AAAA);
        send_request(OP_PUSH, 32'h5555_5555);
        repeat (12) send_request(OP_POP, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_drain(input bit ascending);
        // Ascending values make every push rise to the root.
        while (shadow_fill < HEAP_DEPTH)
            send_request(OP_PUSH, ascending ? shadow_fill * 3 - 90 : random_value(1));
        repeat (4) send_request(OP_PUSH, random_value(0));
        while (shadow_fill > 0) send_request(OP_POP, random_value(0));
        repeat (3) send_request(OP_POP, random_value(0));
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        repeat (200)
            send_request($urandom_range(0, 1) ? OP_POP : OP_PUSH, random_value(0));
        quiet_mode = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_req = 400;
        repeat (16) send_request(OP_PUSH, random_value(0));
    endtask

    task automatic test_random_mix();
        int push_bias;
        int style;
        repeat (11) begin
            case ($urandom_range(0, 2))
                0: push_bias = 25;
                1: push_bias = 50;
                default: push_bias = 80;
            endcase
            style = $urandom_range(0, 2);
            repeat (100)
                send_request(($urandom_range(0, 99) < push_bias) ? OP_PUSH : OP_POP,
                             random_value(style));
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_fill_and_drain(1'b1);
        test_fill_and_drain(1'b0);
        test_back_to_back();
        test_output_backpressure();
        test_random_mix();
        s_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d push and pop requests and checked %0d results,",
                 requests_sent, results_checked);
        $display("including %0d pushes dropped on a full heap and %0d pops on an empty one.",
                 full_drops, empty_pops);
        if (mismatches == 0 && awaited_outcomes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
